[src/pmt_pkg.sv]
// ----------------------------------------------------------------------------
// Midpoint triangulation package
// Widths of the intermediate products, pipeline depths and shared types.
// ----------------------------------------------------------------------------
package pmt_pkg;

    // Data widths of the exact integer datapath.
    localparam int DW   = 32;   // coordinates, centers, directions
    localparam int CW   = 33;   // center difference and center sum
    localparam int AW   = 66;   // dot products of two directions
    localparam int DEW  = 67;   // dot products of a direction with the center difference
    localparam int DENW = 133;  // denominator a*c - b*b
    localparam int SNW  = 134;  // line parameters sn and tn
    localparam int PW   = 166;  // products of the last multiply layer
    localparam int NUMW = 168;  // numerator of one coordinate
    localparam int DIVW = 170;  // dividend and shifted divisor in the divider
    localparam int QB   = 32;   // quotient bits

    // Register stages of the three multiply layers.
    localparam int S1 = 2;
    localparam int S2 = 4;
    localparam int S3 = 2;

    // Configuration registers.
    localparam int NUM_REGS = 6;
    localparam int CFG_IW   = 3;
    localparam int REG_LEFT_CX  = 0;
    localparam int REG_RIGHT_CX = 3;

    // Control word that travels with each beat through the divider.
    typedef struct packed {
        logic vld;
        logic neg;
        logic big;
        logic deg;
    } t_ctl;

endpackage

[src/pmt_dly.sv]
// ----------------------------------------------------------------------------
// Delay line
// Fixed-length register chain for data that rides beside the pipeline.
// ----------------------------------------------------------------------------
module pmt_dly #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_q [N];

    always_ff @(posedge i_clk) begin
        r_q[0] <= i_d;
        for (int k = 1; k < N; k++) begin
            r_q[k] <= r_q[k-1];
        end
    end

    assign o_q = r_q[N-1];

endmodule

[src/pmt_mul.sv]
// ----------------------------------------------------------------------------
// Pipelined signed multiplier
// Multiplies by one digit of the second operand per register stage.
// ----------------------------------------------------------------------------
module pmt_mul #(
    parameter int WA     = 32,
    parameter int WB     = 32,
    parameter int STAGES = 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic signed [WA-1:0]    i_a,
    input  logic signed [WB-1:0]    i_b,
    output logic                    o_vld,
    output logic signed [WA+WB-1:0] o_p
);
    localparam int D   = (WB + STAGES - 1) / STAGES;
    localparam int WBX = D * STAGES;
    localparam int WP  = WA + WB;

    logic signed [WBX-1:0] bx;
    logic signed [WA-1:0]  r_a   [STAGES];
    logic signed [WBX-1:0] r_b   [STAGES];
    logic signed [WP-1:0]  r_acc [STAGES];
    logic                  r_vld [STAGES];

    assign bx = WBX'(i_b);

    for (genvar k = 0; k < STAGES; k++) begin : g_st
        logic signed [WA-1:0]  a_in;
        logic signed [WBX-1:0] b_in;
        logic signed [WP-1:0]  acc_in;
        logic                  vld_in;
        logic [D-1:0]          dig;
        logic signed [WA+D:0]  pp;
        logic signed [WP-1:0]  n_acc;

        if (k == 0) begin : g_first
            assign a_in   = i_a;
            assign b_in   = bx;
            assign acc_in = '0;
            assign vld_in = i_vld;
        end else begin : g_next
            assign a_in   = r_a[k-1];
            assign b_in   = r_b[k-1];
            assign acc_in = r_acc[k-1];
            assign vld_in = r_vld[k-1];
        end

        assign dig = b_in[k*D +: D];

        // The top digit carries the sign of the second operand.
        if (k == STAGES - 1) begin : g_top
            assign pp = a_in * $signed({dig[D-1], dig});
        end else begin : g_low
            assign pp = a_in * $signed({1'b0, dig});
        end

        assign n_acc = acc_in + (WP'(pp) <<< (k * D));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_a[k]   <= a_in;
            r_b[k]   <= b_in;
            r_acc[k] <= n_acc;
        end
    end

    assign o_vld = r_vld[STAGES-1];
    assign o_p   = r_acc[STAGES-1];

endmodule

[src/pmt_div.sv]
// ----------------------------------------------------------------------------
// Pipelined rounding divider
// Restoring division, one quotient bit per stage, then saturation and sign.
// ----------------------------------------------------------------------------
module pmt_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pmt_pkg::t_ctl                i_ctl,
    input  logic [pmt_pkg::DIVW-1:0]     i_num,
    input  logic [pmt_pkg::DIVW-1:0]     i_dvs,
    output pmt_pkg::t_ctl                o_ctl,
    output logic signed [pmt_pkg::DW-1:0] o_res
);
    import pmt_pkg::*;

    t_ctl              r_ctl [QB];
    logic [DIVW-1:0]   r_rem [QB];
    logic [DIVW-1:0]   r_dvs [QB];
    logic [QB-1:0]     r_q   [QB];

    t_ctl              r_ctl_o;
    logic signed [DW-1:0] r_res;
    logic signed [DW-1:0] n_res;
    logic              sat_pos;
    logic              sat_neg;

    for (genvar k = 0; k < QB; k++) begin : g_st
        localparam int BIT = QB - 1 - k;
        t_ctl            ctl_in;
        logic [DIVW-1:0] rem_in;
        logic [DIVW-1:0] dvs_in;
        logic [QB-1:0]   q_in;
        logic [DIVW-1:0] sub;
        logic            ge;
        logic [DIVW-1:0] n_rem;
        logic [QB-1:0]   n_q;

        if (k == 0) begin : g_first
            assign ctl_in = i_ctl;
            assign rem_in = i_num;
            assign dvs_in = i_dvs;
            assign q_in   = '0;
        end else begin : g_next
            assign ctl_in = r_ctl[k-1];
            assign rem_in = r_rem[k-1];
            assign dvs_in = r_dvs[k-1];
            assign q_in   = r_q[k-1];
        end

        assign sub = dvs_in << BIT;
        assign ge  = (rem_in >= sub);

        always_comb begin
            n_rem = ge ? (rem_in - sub) : rem_in;
            n_q = q_in;
            n_q[BIT] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k] <= '0;
            end else begin
                r_ctl[k] <= ctl_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem;
            r_dvs[k] <= dvs_in;
            r_q[k]   <= n_q;
        end
    end

    always_comb begin
        sat_pos = r_ctl[QB-1].big || r_q[QB-1][QB-1];
        sat_neg = r_ctl[QB-1].big || (r_q[QB-1] > {1'b1, {(QB-1){1'b0}}});
        if (r_ctl[QB-1].deg) begin
            n_res = '0;
        end else if (r_ctl[QB-1].neg) begin
            n_res = sat_neg ? {1'b1, {(DW-1){1'b0}}} : DW'(-r_q[QB-1]);
        end else begin
            n_res = sat_pos ? {1'b0, {(DW-1){1'b1}}} : DW'(r_q[QB-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_o <= '0;
        end else begin
            r_ctl_o <= r_ctl[QB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_ctl = r_ctl_o;
    assign o_res = r_res;

endmodule

[src/plucker_midpoint_triangulation.sv]
// ----------------------------------------------------------------------------
// Pluecker-line midpoint triangulation
// Fully pipelined exact midpoint of two back-projected stereo rays.
// ----------------------------------------------------------------------------
// The block takes one point pair per clock cycle: busy is always low, so a
// beat is accepted at every edge where start is high. Each beat produces
// exactly one result, shown for one cycle with o_valid high. The receiver
// cannot stall, and none is needed because nothing inside ever waits. The
// pipeline is made of one input register, three pipelined multiply layers
// of 2, 4 and 2 stages with a register after each (the one after the last
// layer also prepares the rounded division), 32 divider stages (one quotient
// bit each) and the output register. Camera centers are written through the
// plain write port and must only change while no beat is in flight.
// ----------------------------------------------------------------------------
module plucker_midpoint_triangulation (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [31:0]       i_left_dir_x,
    input  logic signed [31:0]       i_left_dir_y,
    input  logic signed [31:0]       i_left_dir_z,
    input  logic signed [31:0]       i_right_dir_x,
    input  logic signed [31:0]       i_right_dir_y,
    input  logic signed [31:0]       i_right_dir_z,
    input  logic                     i_cfg_we,
    input  logic [pmt_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [31:0]              i_cfg_data,
    output logic                     o_valid,
    output logic signed [31:0]       o_point_x,
    output logic signed [31:0]       o_point_y,
    output logic signed [31:0]       o_point_z,
    output logic                     o_degenerate
);
    import pmt_pkg::*;

    localparam int LAT  = 1 + S1 + 1 + S2 + 1 + S3 + 1 + QB + 1;
    localparam int SIDW = 6 * DW + 3 * CW;

    // The pipeline never refuses a beat.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Camera centers. Writes to an index past the last register are
    // dropped.
    // ------------------------------------------------------------------
    logic [DW-1:0] r_cfg [NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_cfg[k] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_idx < CFG_IW'(NUM_REGS))) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Input register: capture the directions and form the center
    // difference w = CL - CR and the center sum CL + CR.
    // ------------------------------------------------------------------
    logic signed [DW-1:0] in_dl [3];
    logic signed [DW-1:0] in_dr [3];
    logic signed [DW-1:0] r0_dl [3];
    logic signed [DW-1:0] r0_dr [3];
    logic signed [CW-1:0] r0_w  [3];
    logic signed [CW-1:0] r0_s  [3];
    logic                 r0_vld;

    assign in_dl[0] = i_left_dir_x;
    assign in_dl[1] = i_left_dir_y;
    assign in_dl[2] = i_left_dir_z;
    assign in_dr[0] = i_right_dir_x;
    assign in_dr[1] = i_right_dir_y;
    assign in_dr[2] = i_right_dir_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else begin
            r0_vld <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r0_dl[k] <= in_dl[k];
            r0_dr[k] <= in_dr[k];
            r0_w[k]  <= CW'($signed(r_cfg[REG_LEFT_CX + k]))
                      - CW'($signed(r_cfg[REG_RIGHT_CX + k]));
            r0_s[k]  <= CW'($signed(r_cfg[REG_LEFT_CX + k]))
                      + CW'($signed(r_cfg[REG_RIGHT_CX + k]));
        end
    end

    // ------------------------------------------------------------------
    // First multiply layer: the fifteen coordinate products that make up
    // the dot products a, b, c, d and e.
    // ------------------------------------------------------------------
    logic signed [2*DW-1:0]  p_ll [3];
    logic signed [2*DW-1:0]  p_lr [3];
    logic signed [2*DW-1:0]  p_rr [3];
    logic signed [DW+CW-1:0] p_lw [3];
    logic signed [DW+CW-1:0] p_rw [3];
    logic [2:0]              m1_vld;

    for (genvar i = 0; i < 3; i++) begin : g_m1
        pmt_mul #(.WA(DW), .WB(DW), .STAGES(S1)) u_ll (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r0_vld),
            .i_a(r0_dl[i]), .i_b(r0_dl[i]), .o_vld(m1_vld[i]), .o_p(p_ll[i])
        );
        pmt_mul #(.WA(DW), .WB(DW), .STAGES(S1)) u_lr (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r0_vld),
            .i_a(r0_dl[i]), .i_b(r0_dr[i]), .o_vld(), .o_p(p_lr[i])
        );
        pmt_mul #(.WA(DW), .WB(DW), .STAGES(S1)) u_rr (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r0_vld),
            .i_a(r0_dr[i]), .i_b(r0_dr[i]), .o_vld(), .o_p(p_rr[i])
        );
        pmt_mul #(.WA(DW), .WB(CW), .STAGES(S1)) u_lw (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r0_vld),
            .i_a(r0_dl[i]), .i_b(r0_w[i]), .o_vld(), .o_p(p_lw[i])
        );
        pmt_mul #(.WA(DW), .WB(CW), .STAGES(S1)) u_rw (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r0_vld),
            .i_a(r0_dr[i]), .i_b(r0_w[i]), .o_vld(), .o_p(p_rw[i])
        );
    end

    // ------------------------------------------------------------------
    // Dot products: a = dL.dL, b = dL.dR, c = dR.dR, d = dL.w, e = dR.w.
    // ------------------------------------------------------------------
    logic signed [AW-1:0]  r2_a;
    logic signed [AW-1:0]  r2_b;
    logic signed [AW-1:0]  r2_c;
    logic signed [DEW-1:0] r2_d;
    logic signed [DEW-1:0] r2_e;
    logic                  r2_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= m1_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        r2_a <= AW'(p_ll[0]) + AW'(p_ll[1]) + AW'(p_ll[2]);
        r2_b <= AW'(p_lr[0]) + AW'(p_lr[1]) + AW'(p_lr[2]);
        r2_c <= AW'(p_rr[0]) + AW'(p_rr[1]) + AW'(p_rr[2]);
        r2_d <= DEW'(p_lw[0]) + DEW'(p_lw[1]) + DEW'(p_lw[2]);
        r2_e <= DEW'(p_rw[0]) + DEW'(p_rw[1]) + DEW'(p_rw[2]);
    end

    // ------------------------------------------------------------------
    // Second multiply layer: a*c, b*b, b*e, c*d, a*e and b*d.
    // ------------------------------------------------------------------
    logic signed [2*AW-1:0]   p_ac;
    logic signed [2*AW-1:0]   p_bb;
    logic signed [AW+DEW-1:0] p_be;
    logic signed [AW+DEW-1:0] p_cd;
    logic signed [AW+DEW-1:0] p_ae;
    logic signed [AW+DEW-1:0] p_bd;
    logic                     m2_vld;

    pmt_mul #(.WA(AW), .WB(AW), .STAGES(S2)) u_ac (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r2_vld),
        .i_a(r2_a), .i_b(r2_c), .o_vld(m2_vld), .o_p(p_ac)
    );
    pmt_mul #(.WA(AW), .WB(AW), .STAGES(S2)) u_bb (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r2_vld),
        .i_a(r2_b), .i_b(r2_b), .o_vld(), .o_p(p_bb)
    );
    pmt_mul #(.WA(AW), .WB(DEW), .STAGES(S2)) u_be (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r2_vld),
        .i_a(r2_b), .i_b(r2_e), .o_vld(), .o_p(p_be)
    );
    pmt_mul #(.WA(AW), .WB(DEW), .STAGES(S2)) u_cd (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r2_vld),
        .i_a(r2_c), .i_b(r2_d), .o_vld(), .o_p(p_cd)
    );
    pmt_mul #(.WA(AW), .WB(DEW), .STAGES(S2)) u_ae (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r2_vld),
        .i_a(r2_a), .i_b(r2_e), .o_vld(), .o_p(p_ae)
    );
    pmt_mul #(.WA(AW), .WB(DEW), .STAGES(S2)) u_bd (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r2_vld),
        .i_a(r2_b), .i_b(r2_d), .o_vld(), .o_p(p_bd)
    );

    // ------------------------------------------------------------------
    // Denominator den = a*c - b*b and line parameters sn, tn. The rays
    // are parallel or one is zero exactly when den is not positive.
    // ------------------------------------------------------------------
    logic signed [DENW-1:0] r4_den;
    logic signed [SNW-1:0]  r4_sn;
    logic signed [SNW-1:0]  r4_tn;
    logic signed [DENW-1:0] n_den;
    logic                   r4_deg;
    logic                   r4_vld;

    assign n_den = DENW'(p_ac) - DENW'(p_bb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= m2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_den <= n_den;
        r4_deg <= (n_den == '0) || n_den[DENW-1];
        r4_sn  <= SNW'(p_be) - SNW'(p_cd);
        r4_tn  <= SNW'(p_ae) - SNW'(p_bd);
    end

    // The directions and the center sum wait beside the first two layers.
    logic [SIDW-1:0] side_in;
    logic [SIDW-1:0] side_out;
    logic signed [DW-1:0] d_dl [3];
    logic signed [DW-1:0] d_dr [3];
    logic signed [CW-1:0] d_s  [3];

    assign side_in = {r0_dl[0], r0_dl[1], r0_dl[2], r0_dr[0], r0_dr[1], r0_dr[2],
                      r0_s[0], r0_s[1], r0_s[2]};

    pmt_dly #(.W(SIDW), .N(S1 + 1 + S2 + 1)) u_side (
        .i_clk(i_clk), .i_d(side_in), .o_q(side_out)
    );

    for (genvar i = 0; i < 3; i++) begin : g_unpack
        assign d_dl[i] = side_out[SIDW - 1 - i*DW -: DW];
        assign d_dr[i] = side_out[SIDW - 1 - (3 + i)*DW -: DW];
        assign d_s[i]  = side_out[3*CW - 1 - i*CW -: CW];
    end

    // The denominator and the degenerate flag wait beside the last layer.
    logic [DENW-1:0] d_den;
    logic            d_deg;

    pmt_dly #(.W(DENW + 1), .N(S3)) u_den (
        .i_clk(i_clk), .i_d({r4_den, r4_deg}), .o_q({d_den, d_deg})
    );

    // ------------------------------------------------------------------
    // Third multiply layer and numerator per coordinate:
    // num = (CL+CR)*den + sn*dL + tn*dR. The rounded quotient is
    // floor((|num| + den) / (2*den)); the preparation register also flags
    // a quotient that needs more than 32 bits.
    // ------------------------------------------------------------------
    logic signed [DW-1:0] res [3];
    t_ctl                 res_ctl [3];
    logic [2:0]           m3_vld;

    for (genvar i = 0; i < 3; i++) begin : g_axis
        logic signed [PW-1:0]   p_sd;
        logic signed [PW-1:0]   p_sl;
        logic signed [PW-1:0]   p_tr;
        logic signed [NUMW-1:0] num;
        logic [NUMW-1:0]        mag;
        logic [DIVW-1:0]        n_num;
        logic [DIVW-1:0]        n_dvs;
        t_ctl                   n_ctl;
        t_ctl                   r6_ctl;
        logic [DIVW-1:0]        r6_num;
        logic [DIVW-1:0]        r6_dvs;

        pmt_mul #(.WA(DENW), .WB(CW), .STAGES(S3)) u_sd (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r4_vld),
            .i_a(r4_den), .i_b(d_s[i]), .o_vld(m3_vld[i]), .o_p(p_sd)
        );
        pmt_mul #(.WA(SNW), .WB(DW), .STAGES(S3)) u_sl (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r4_vld),
            .i_a(r4_sn), .i_b(d_dl[i]), .o_vld(), .o_p(p_sl)
        );
        pmt_mul #(.WA(SNW), .WB(DW), .STAGES(S3)) u_tr (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r4_vld),
            .i_a(r4_tn), .i_b(d_dr[i]), .o_vld(), .o_p(p_tr)
        );

        always_comb begin
            num   = NUMW'(p_sd) + NUMW'(p_sl) + NUMW'(p_tr);
            mag   = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
            n_num = DIVW'(mag) + DIVW'(d_den);
            n_dvs = DIVW'(d_den) << 1;
            n_ctl.vld = m3_vld[i];
            n_ctl.neg = num[NUMW-1];
            n_ctl.big = (n_num >= (n_dvs << QB));
            n_ctl.deg = d_deg;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r6_ctl <= '0;
            end else begin
                r6_ctl <= n_ctl;
            end
        end

        always_ff @(posedge i_clk) begin
            r6_num <= n_num;
            r6_dvs <= n_dvs;
        end

        pmt_div u_div (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(r6_ctl),
            .i_num(r6_num), .i_dvs(r6_dvs), .o_ctl(res_ctl[i]), .o_res(res[i])
        );
    end

    assign o_valid      = res_ctl[0].vld;
    assign o_degenerate = res_ctl[0].deg;
    assign o_point_x    = res[0];
    assign o_point_y    = res[1];
    assign o_point_z    = res[2];

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_beat_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_valid)
        else $error("accepted beat did not produce a result");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |-> ##LAT !o_valid)
        else $error("result appeared without an accepted beat");

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |->
            (o_point_x == '0 && o_point_y == '0 && o_point_z == '0))
        else $error("degenerate result carries a nonzero point");

endmodule

[tb/sv/plucker_midpoint_triangulation_tb.sv]
// ----------------------------------------------------------------------------
// Midpoint triangulation testbench
// Drives stereo ray pairs through the triangulation pipeline under several
// camera-center settings and checks every result against a directed point or
// an exact wide-integer predictor of the midpoint, rounding and saturation.
// ----------------------------------------------------------------------------
module plucker_midpoint_triangulation_tb;
    import pmt_pkg::*;

    // Exact arithmetic is done in 256-bit signed integers. That is wide enough
    // for every product that the midpoint formula forms.
    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               deg;
    } point_t;

    // One directed row: left x, y, z and right x, y, z, plus an optional
    // expected point that can be read straight off the formula.
    typedef struct {
        logic [5:0][31:0] dirs;
        bit               typed;
        point_t           want;
    } dir_row_t;

    localparam int LATENCY   = 45;
    localparam int CYCLE_CAP = 400000;
    localparam int N_RANDOM  = 1325;
    localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [31:0] MINV = 32'h8000_0000;
    localparam logic [31:0] ONE  = 32'h0001_0000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic signed [31:0]       i_left_dir_x, i_left_dir_y, i_left_dir_z;
    logic signed [31:0]       i_right_dir_x, i_right_dir_y, i_right_dir_z;
    logic                     i_cfg_we;
    logic [CFG_IW-1:0]        i_cfg_idx;
    logic [31:0]              i_cfg_data;
    logic                     o_valid;
    logic signed [31:0]       o_point_x, o_point_y, o_point_z;
    logic                     o_degenerate;

    plucker_midpoint_triangulation i_dut (.*);

    // Our own copy of the six camera-center registers.
    logic [NUM_REGS-1:0][31:0] centers;
    point_t                    pending_points[$];
    int                        mismatches;
    int                        cycles;
    bit                        idle_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The run is bounded so that a hung pipeline still ends the test.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic wide_t widen(logic [31:0] v);
        return {{224{v[31]}}, v};
    endfunction

    // Closest-point midpoint of the two rays, formed exactly as a rational
    // number and rounded once, ties away from zero, then saturated.
    function automatic point_t predict_midpoint(logic [5:0][31:0] dirs);
        wide_t  cl[3], cr[3], dl[3], dr[3], w[3];
        wide_t  a, b, c, dd, e, den, sn, tn, num, mag, q;
        logic   [2:0][31:0] coord;
        logic   neg;
        point_t p;
        for (int i = 0; i < 3; i++) begin
            cl[i] = widen(centers[REG_LEFT_CX + i]);
            cr[i] = widen(centers[REG_RIGHT_CX + i]);
            dl[i] = widen(dirs[i]);
            dr[i] = widen(dirs[3 + i]);
            w[i]  = cl[i] - cr[i];
        end
        a   = dl[0] * dl[0] + dl[1] * dl[1] + dl[2] * dl[2];
        b   = dl[0] * dr[0] + dl[1] * dr[1] + dl[2] * dr[2];
        c   = dr[0] * dr[0] + dr[1] * dr[1] + dr[2] * dr[2];
        dd  = dl[0] * w[0] + dl[1] * w[1] + dl[2] * w[2];
        e   = dr[0] * w[0] + dr[1] * w[1] + dr[2] * w[2];
        den = a * c - b * b;
        if (den <= 0) begin
            p = '{x: '0, y: '0, z: '0, deg: 1'b1};
            return p;
        end
        sn = b * e - c * dd;
        tn = a * e - b * dd;
        for (int i = 0; i < 3; i++) begin
            num = (cl[i] + cr[i]) * den + sn * dl[i] + tn * dr[i];
            neg = num < 0;
            mag = neg ? -num : num;
            q   = (mag + den) / (den + den);
            if (neg)
                coord[i] = (q > widen(MINV) * -1) ? MINV : 32'(-q);
            else
                coord[i] = (q > widen(MAXV)) ? MAXV : q[31:0];
        end
        p = '{x: coord[0], y: coord[1], z: coord[2], deg: 1'b0};
        return p;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        $display("mismatch on %s at cycle %0d: expected %h, got %h",
                 field, cycles, want, got);
        mismatches++;
    endtask

    // Results cannot be held off, so every strobe is checked at the edge that
    // ends its cycle, against the oldest point still waiting.
    always @(posedge i_clk) begin
        point_t want;
        if (i_rst_n && o_valid) begin
            if (pending_points.size() == 0) begin
                report_mismatch("unexpected result beat", 32'd0, 32'd1);
            end else begin
                want = pending_points.pop_front();
                if (o_point_x !== want.x) report_mismatch("point_x", want.x, o_point_x);
                if (o_point_y !== want.y) report_mismatch("point_y", want.y, o_point_y);
                if (o_point_z !== want.z) report_mismatch("point_z", want.z, o_point_z);
                if (o_degenerate !== want.deg)
                    report_mismatch("degenerate", 32'(want.deg), 32'(o_degenerate));
            end
        end
    end

    // Presents one beat and holds it until busy is seen low at an edge. The
    // start line is left high so that back-to-back beats need no toggle.
    task automatic send_rays(logic [5:0][31:0] dirs, bit typed = 0, point_t want = '0);
        start         <= 1'b1;
        i_left_dir_x  <= dirs[0];
        i_left_dir_y  <= dirs[1];
        i_left_dir_z  <= dirs[2];
        i_right_dir_x <= dirs[3];
        i_right_dir_y <= dirs[4];
        i_right_dir_z <= dirs[5];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_points.push_back(typed ? want : predict_midpoint(dirs));
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    // Centers may change only with the pipeline empty: wait for every result,
    // then for the pipeline depth so that nothing is left in flight.
    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // One write per call; the enable is dropped before the next write can
    // raise it again.
    task automatic write_center(int idx, logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx[CFG_IW-1:0];
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx < NUM_REGS) centers[idx] = val;
        @(posedge i_clk);
    endtask

    // A coordinate that is either tame (within 2^25 of zero) or anything.
    function automatic logic [31:0] pick_coord(bit tame);
        if (tame) return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
        case ($urandom_range(0, 5))
            0:       return MAXV;
            1:       return MINV;
            2:       return 32'($urandom_range(0, 3)) - 32'd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic load_centers(int mode);
        for (int i = 0; i < NUM_REGS; i++) begin
            case (mode)
                0:       write_center(i, '0);
                1:       write_center(i, pick_coord(1));
                2:       write_center(i, (i % 2) ? MAXV : MINV);
                default: write_center(i, pick_coord(0));
            endcase
        end
    endtask

    // Mostly well-formed pairs: with tame centers both rays are aimed at one
    // scene point with a little noise, which exercises the full closest-point
    // path. The rest are parallel rays, zero rays and unrestricted noise.
    function automatic logic [5:0][31:0] make_pair(bit tame);
        logic [5:0][31:0] dirs;
        logic [31:0]      k;
        case ($urandom_range(0, 9))
            0: begin
                for (int i = 0; i < 6; i++) dirs[i] = $urandom;
            end
            1: begin
                k = 32'($urandom_range(1, 4));
                for (int i = 0; i < 3; i++) begin
                    dirs[i]     = 32'($signed($urandom_range(0, 32'hFFFF)) - 32'sh8000);
                    dirs[3 + i] = ($urandom_range(0, 1) ? k : -k) * dirs[i];
                end
            end
            2: begin
                for (int i = 0; i < 6; i++) dirs[i] = (i < 3) ? '0 : pick_coord(tame);
                if ($urandom_range(0, 1)) dirs = {dirs[2:0], dirs[5:3]};
            end
            default: begin
                for (int i = 0; i < 3; i++) begin
                    k           = pick_coord(1) + 32'(i == 2 ? 32'sh0800_0000 : 0);
                    dirs[i]     = k - (tame ? centers[REG_LEFT_CX + i] : '0)
                                  + 32'($urandom_range(0, 255));
                    dirs[3 + i] = k - (tame ? centers[REG_RIGHT_CX + i] : '0)
                                  - 32'($urandom_range(0, 255));
                end
            end
        endcase
        return dirs;
    endfunction

    initial begin
        dir_row_t rows[$];
        point_t   zero_deg;
        zero_deg   = '{x: '0, y: '0, z: '0, deg: 1'b1};
        mismatches = 0;
        cycles     = 0;
        idle_on    = 1'b1;
        centers    = '0;
        start      = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        {i_left_dir_x, i_left_dir_y, i_left_dir_z} = '0;
        {i_right_dir_x, i_right_dir_y, i_right_dir_z} = '0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows with the centers at their reset value of zero. Zero
        // and parallel rays give the degenerate flag with a zero point; two
        // crossing rays from the origin meet at the origin.
        rows.push_back('{'{'0, '0, '0, '0, '0, '0}, 1, zero_deg});
        rows.push_back('{'{'0, '0, '0, ONE, '0, '0}, 1, zero_deg});
        rows.push_back('{'{ONE, '0, '0, '0, '0, '0}, 1, zero_deg});
        rows.push_back('{'{ONE, ONE, ONE, ONE, ONE, ONE}, 1, zero_deg});
        rows.push_back('{'{ONE, '0, '0, -ONE, '0, '0}, 1, zero_deg});
        rows.push_back('{'{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}, 1, zero_deg});
        rows.push_back('{'{MINV, MINV, MINV, MINV, MINV, MINV}, 1, zero_deg});
        rows.push_back('{'{ONE, '0, '0, '0, ONE, '0}, 1, '0});
        rows.push_back('{'{MAXV, '0, '0, '0, '0, MINV}, 1, '0});
        rows.push_back('{'{MINV, MAXV, '0, MAXV, MINV, 32'd1}, 0, '0});
        rows.push_back('{'{32'd1, '0, '0, '0, 32'd1, '0}, 1, '0});
        foreach (rows[r]) send_rays(rows[r].dirs, rows[r].typed, rows[r].want);
        drain();

        // Extreme centers: every register at one end of its range, plus
        // writes to the two unused indexes, which must change nothing.
        load_centers(2);
        write_center(NUM_REGS, MAXV);
        write_center(NUM_REGS + 1, MINV);
        send_rays('{ONE, '0, '0, '0, ONE, '0});
        send_rays('{'0, ONE, ONE, ONE, '0, MINV});
        send_rays('{MAXV, 32'd3, MINV, 32'd7, MAXV, 32'd1});
        send_rays('{'0, '0, '0, ONE, ONE, '0}, 1, zero_deg);
        send_rays('{32'd1, 32'd2, 32'd3, 32'd2, 32'd4, 32'd6}, 1, zero_deg);
        send_rays('{ONE, 32'd1, '0, 32'd1, ONE, '0});
        drain();

        // Random phases, each of which loads the centers anew. The last
        // phase runs with no gaps at all.
        for (int phase = 0; phase < 6; phase++) begin
            bit tame;
            load_centers(phase == 5 ? 1 : phase % 4);
            tame    = (phase % 4) < 2;
            idle_on = (phase != 5);
            for (int n = 0; n < N_RANDOM / 6; n++) send_rays(make_pair(tame));
            drain();
        end

        if (pending_points.size() != 0)
            report_mismatch("missing results", 32'd0, 32'(pending_points.size()));
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
